>>> rtl/shp_pkg.sv
// ----------------------------------------------------------------------------
// shp_pkg
// Shared types and constants of the 3x3 sharpening window filter.
// ----------------------------------------------------------------------------
package shp_pkg;

  localparam int CH_BITS        = 8;
  localparam int NUM_CH         = 3;
  localparam int NUM_ROWS       = 3;
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int WIDTH_BITS     = 12;
  localparam int HEIGHT_BITS    = 16;
  localparam int LEVEL_BITS     = 8;
  localparam int SUM_BITS       = 11;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 16;

  typedef logic [CH_BITS-1:0]  smp_t;
  typedef smp_t [NUM_CH-1:0]   pix_t;   // [0] chan_a, [1] chan_b, [2] chan_c
  typedef pix_t [NUM_ROWS-1:0] col_t;   // [0] upper, [1] middle, [2] lower

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FILTER_MODE  = 3'd0,
    CFG_SHARP_LEVEL  = 3'd1,
    CFG_IMAGE_WIDTH  = 3'd2,
    CFG_IMAGE_HEIGHT = 3'd3,
    CFG_COLOR_LAYOUT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic                   highpass;
    logic [LEVEL_BITS-1:0]  level;
    logic [WIDTH_BITS-1:0]  width;
    logic [HEIGHT_BITS-1:0] height;
    logic                   color;
  } cfg_t;

  typedef struct packed {
    logic [NUM_CH-1:0][SUM_BITS-1:0] sum;
    pix_t                            center;
    logic                            run_end;
    logic                            frame_end;
  } job_t;

endpackage

>>> rtl/shp_if.sv
// ----------------------------------------------------------------------------
// shp_if
// Stream and configuration channels of the sharpening filter.
// ----------------------------------------------------------------------------
interface shp_in_if import shp_pkg::*; ();
  logic valid;
  logic ready;
  smp_t chan_a;
  smp_t chan_b;
  smp_t chan_c;

  modport source (output valid, chan_a, chan_b, chan_c, input ready);
  modport sink   (input valid, chan_a, chan_b, chan_c, output ready);
endinterface

interface shp_out_if import shp_pkg::*; ();
  logic valid;
  logic ready;
  smp_t out_a;
  smp_t out_b;
  smp_t out_c;
  logic run_end;
  logic frame_end;

  modport source (output valid, out_a, out_b, out_c, run_end, frame_end, input ready);
  modport sink   (input valid, out_a, out_b, out_c, run_end, frame_end, output ready);
endinterface

interface shp_cfg_if import shp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/shp_row_mem.sv
// ----------------------------------------------------------------------------
// shp_row_mem
// Line buffer memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module shp_row_mem #(
  parameter int DEPTH = 2048,
  parameter int DW    = 48
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/shp_window_ctrl.sv
// ----------------------------------------------------------------------------
// shp_window_ctrl
// Raster position, line buffer access, window columns and result sequencing.
// ----------------------------------------------------------------------------
module shp_window_ctrl import shp_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  pix_t in_pix,
  output logic job_valid,
  input  logic job_ready,
  output job_t job
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WB = (CW + 1 > WIDTH_BITS) ? CW + 1 : WIDTH_BITS;

  // position of the next pixel
  logic [CW-1:0]          col_cnt_r;
  logic [HEIGHT_BITS-1:0] row_cnt_r;

  logic [WB-1:0]          w_eff;
  logic [WB-1:0]          x_inc;
  logic [HEIGHT_BITS:0]   h_eff;
  logic [HEIGHT_BITS:0]   y_inc;
  logic                   last_col;
  logic                   last_row;
  logic                   accept;

  // read stage
  logic                   s1_valid_r;
  logic [CW-1:0]          s1_x_r;
  logic                   s1_top_r;
  logic                   s1_lastr_r;
  logic                   s1_lastc_r;
  pix_t                   s1_pix_r;
  logic                   s1_adv;
  logic [3:0]             s1_mask;
  logic                   s1_has_a;

  pix_t [1:0]             mem_rd;
  pix_t [1:0]             row_data;
  logic                   byp_valid_r;
  logic [CW-1:0]          byp_addr_r;
  pix_t [1:0]             byp_data_r;
  col_t                   cur;

  col_t                   wc0_r;
  col_t                   wc1_r;

  // sequencing stage
  logic                   s2_valid_r;
  logic [3:0]             s2_mask_r;
  col_t                   s2_l_r;
  col_t                   s2_c_r;
  col_t                   s2_r_r;
  logic                   s2_acol_r;
  logic                   s2_fire;
  logic                   s2_free;
  logic [1:0]             sel_idx;
  logic [3:0]             sel_hot;
  logic [3:0]             rem_mask;
  logic                   sel_last;

  col_t                   lc;
  col_t                   cc;
  col_t                   rc;
  logic [1:0]             tr;
  logic [1:0]             mr;
  job_t                   job_nxt;

  logic                   j_valid_r;
  job_t                   j_r;
  logic                   j_can;

  always_comb begin
    w_eff = WB'(cfg.width);
    if (cfg.width == '0) begin
      w_eff = WB'(1);
    end else if (WB'(cfg.width) > WB'(MAX_WIDTH)) begin
      w_eff = WB'(MAX_WIDTH);
    end
    h_eff = (cfg.height == '0) ? (HEIGHT_BITS+1)'(1) : {1'b0, cfg.height};
    x_inc = WB'(col_cnt_r) + WB'(1);
    y_inc = {1'b0, row_cnt_r} + (HEIGHT_BITS+1)'(1);
    last_col = (x_inc >= w_eff);
    last_row = (y_inc >= h_eff);
  end

  assign accept   = in_valid && in_ready;
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_cnt_r <= '0;
        row_cnt_r <= last_row ? '0 : y_inc[HEIGHT_BITS-1:0];
      end else begin
        col_cnt_r <= x_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x_r     <= col_cnt_r;
      s1_top_r   <= (row_cnt_r == '0);
      s1_lastr_r <= last_row;
      s1_lastc_r <= last_col;
      s1_pix_r   <= in_pix;
    end
  end

  shp_row_mem #(
    .DEPTH (MAX_WIDTH),
    .DW    (2 * NUM_CH * CH_BITS)
  ) u_row_mem (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_x_r),
    .wr_data ({cur[1], cur[2]}),
    .rd_en   (accept),
    .rd_addr (col_cnt_r),
    .rd_data (mem_rd)
  );

  // forward the last write over the stale read word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_valid_r <= 1'b0;
    end else if (s1_adv) begin
      byp_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      byp_addr_r <= s1_x_r;
      byp_data_r <= {cur[1], cur[2]};
    end
  end

  always_comb begin
    row_data = (byp_valid_r && (byp_addr_r == s1_x_r)) ? byp_data_r : mem_rd;
    cur[2]   = s1_pix_r;
    cur[0]   = s1_top_r ? s1_pix_r : row_data[1];
    cur[1]   = s1_top_r ? s1_pix_r : row_data[0];
  end

  always_comb begin
    s1_has_a   = (s1_x_r != '0);
    s1_mask[0] = s1_has_a && !s1_top_r;
    s1_mask[1] = s1_has_a && s1_lastr_r;
    s1_mask[2] = s1_lastc_r && !s1_top_r;
    s1_mask[3] = s1_lastc_r && s1_lastr_r;
  end

  assign s1_adv = s1_valid_r && ((s1_mask == '0) || s2_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc0_r <= '0;
      wc1_r <= '0;
    end else if (s1_adv) begin
      wc1_r <= wc0_r;
      wc0_r <= cur;
    end
  end

  // pick the next pending result of the held pixel
  always_comb begin
    priority if (s2_mask_r[0]) begin
      sel_idx = 2'd0;
    end else if (s2_mask_r[1]) begin
      sel_idx = 2'd1;
    end else if (s2_mask_r[2]) begin
      sel_idx = 2'd2;
    end else begin
      sel_idx = 2'd3;
    end
    sel_hot  = 4'b0001 << sel_idx;
    rem_mask = s2_mask_r & ~sel_hot;
    sel_last = (rem_mask == '0);
  end

  assign j_can   = !j_valid_r || job_ready;
  assign s2_fire = s2_valid_r && j_can;
  assign s2_free = !s2_valid_r || (s2_fire && sel_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s2_mask_r  <= '0;
    end else if (s1_adv && (s1_mask != '0)) begin
      s2_valid_r <= 1'b1;
      s2_mask_r  <= s1_mask;
    end else if (s2_fire) begin
      s2_valid_r <= !sel_last;
      s2_mask_r  <= rem_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && (s1_mask != '0)) begin
      s2_l_r    <= (s1_x_r == CW'(1)) ? wc0_r : wc1_r;
      s2_c_r    <= wc0_r;
      s2_r_r    <= cur;
      s2_acol_r <= s1_has_a;
    end
  end

  // window sums for the selected column and row set
  always_comb begin
    if (sel_idx[1]) begin
      lc = s2_acol_r ? s2_c_r : s2_r_r;
      cc = s2_r_r;
      rc = '0;
    end else begin
      lc = s2_l_r;
      cc = s2_c_r;
      rc = s2_r_r;
    end
    tr = sel_idx[0] ? 2'd1 : 2'd0;
    mr = sel_idx[0] ? 2'd2 : 2'd1;
    for (int k = 0; k < NUM_CH; k++) begin
      job_nxt.sum[k] = SUM_BITS'(lc[tr][k]) + SUM_BITS'(cc[tr][k]) + SUM_BITS'(rc[tr][k])
                     + SUM_BITS'(lc[mr][k]) + SUM_BITS'(rc[mr][k])
                     + SUM_BITS'(lc[2][k]) + SUM_BITS'(cc[2][k]) + SUM_BITS'(rc[2][k]);
    end
    job_nxt.center    = cc[mr];
    job_nxt.run_end   = sel_last;
    job_nxt.frame_end = (sel_idx == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_valid_r <= 1'b0;
    end else if (s2_fire) begin
      j_valid_r <= 1'b1;
    end else if (job_ready) begin
      j_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      j_r <= job_nxt;
    end
  end

  assign job_valid = j_valid_r;
  assign job       = j_r;

endmodule

>>> rtl/shp_sharpen_core.sv
// ----------------------------------------------------------------------------
// shp_sharpen_core
// Per-channel unsharp or highpass sharpening with clamp, output register.
// ----------------------------------------------------------------------------
module shp_sharpen_core import shp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job,
  output logic out_valid,
  input  logic out_ready,
  output pix_t out_pix,
  output logic out_run_end,
  output logic out_frame_end
);

  function automatic smp_t sharpen_ch(input smp_t c, input logic [SUM_BITS-1:0] s,
                                      input logic hp, input logic [LEVEL_BITS-1:0] lv);
    logic signed [9:0]  d;
    logic signed [10:0] d2;
    logic signed [12:0] e;
    logic signed [20:0] p;
    logic signed [17:0] v;
    smp_t               res;
    d  = $signed({2'b0, c}) - $signed({2'b0, s[SUM_BITS-1:3]});
    d2 = d[9] ? ($signed({d[9], d}) - $signed({3'b0, lv}))
              : ($signed({d[9], d}) + $signed({3'b0, lv}));
    e  = $signed({2'b0, c, 3'b0}) - $signed({2'b0, s});
    p  = e * $signed({1'b0, lv});
    if (hp) begin
      v = $signed({p[20], p[20:4]}) + $signed({10'b0, c});
    end else begin
      v = $signed({{7{d2[10]}}, d2}) + $signed({10'b0, c});
    end
    if (v[17]) begin
      res = '0;
    end else if (|v[16:8]) begin
      res = '1;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  logic o_valid_r;
  pix_t o_pix_r;
  logic o_run_end_r;
  logic o_frame_end_r;
  pix_t pix_nxt;

  assign job_ready = !o_valid_r || out_ready;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      pix_nxt[k] = sharpen_ch(job.center[k], job.sum[k], cfg.highpass, cfg.level);
    end
    // gray layout keeps only the first channel
    if (!cfg.color) begin
      pix_nxt[1] = '0;
      pix_nxt[2] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (job_ready) begin
      o_valid_r <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      o_pix_r       <= pix_nxt;
      o_run_end_r   <= job.run_end;
      o_frame_end_r <= job.frame_end;
    end
  end

  assign out_valid     = o_valid_r;
  assign out_pix       = o_pix_r;
  assign out_run_end   = o_run_end_r;
  assign out_frame_end = o_frame_end_r;

endmodule

>>> rtl/sharpen_3x3_window_filter.sv
// A pixel's results pass the read, sequencing and job registers into the output register.
// Throughput: one pixel per cycle while each pixel gives at most one result and the output
// is not stalled; a pixel with more results holds the input while the result sequencer
// issues one result per cycle unless stalled; the final pixel of a frame gives up to four.
// The row store is read at acceptance and written when the pixel leaves the read stage.
// Reset: counters, window columns, valid flags and config; row store is not cleared.
// ----------------------------------------------------------------------------
// sharpen_3x3_window_filter
// 3x3 unsharp / highpass sharpening over a raster pixel stream.
// ----------------------------------------------------------------------------
module sharpen_3x3_window_filter import shp_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input logic clk,
  input logic rst_n,
  shp_in_if.sink    in_stream,
  shp_out_if.source out_stream,
  shp_cfg_if.sink   cfg_bus
);

  cfg_t cfg_r;
  logic job_valid;
  logic job_ready;
  job_t job;
  pix_t out_pix;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.highpass <= 1'b0;
      cfg_r.level    <= '0;
      cfg_r.width    <= WIDTH_BITS'(1);
      cfg_r.height   <= HEIGHT_BITS'(1);
      cfg_r.color    <= 1'b1;
    end else if (cfg_bus.valid) begin
      unique case (cfg_idx_t'(cfg_bus.index))
        CFG_FILTER_MODE:  cfg_r.highpass <= cfg_bus.data[0];
        CFG_SHARP_LEVEL:  cfg_r.level    <= cfg_bus.data[LEVEL_BITS-1:0];
        CFG_IMAGE_WIDTH:  cfg_r.width    <= cfg_bus.data[WIDTH_BITS-1:0];
        CFG_IMAGE_HEIGHT: cfg_r.height   <= cfg_bus.data[HEIGHT_BITS-1:0];
        CFG_COLOR_LAYOUT: cfg_r.color    <= cfg_bus.data[0];
        default: begin
        end
      endcase
    end
  end

  shp_window_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_stream.valid),
    .in_ready  (in_stream.ready),
    .in_pix    ({in_stream.chan_c, in_stream.chan_b, in_stream.chan_a}),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  shp_sharpen_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .job_valid     (job_valid),
    .job_ready     (job_ready),
    .job           (job),
    .out_valid     (out_stream.valid),
    .out_ready     (out_stream.ready),
    .out_pix       (out_pix),
    .out_run_end   (out_stream.run_end),
    .out_frame_end (out_stream.frame_end)
  );

  assign out_stream.out_a = out_pix[0];
  assign out_stream.out_b = out_pix[1];
  assign out_stream.out_c = out_pix[2];

endmodule
